// ----- hdl/joint_encoder_fusion_extrapolator_top_assert.svh -----
// assertion macros for the joint encoder fusion top level
`ifndef JOINT_ENCODER_FUSION_EXTRAPOLATOR_TOP_ASSERT_SVH
`define JOINT_ENCODER_FUSION_EXTRAPOLATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JEFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jefe check failed");

// next-cycle implication, disabled during reset
`define JEFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jefe check failed");

`endif

// ----- hdl/jefe_pkg.sv -----
// types, constants and helper functions for the joint encoder fusion block
`default_nettype none

package jefe_pkg;

   // tracked position width and fractional bits of the elapsed time
   localparam int ANGLE_WIDTH    = 32;
   localparam int TIME_FRAC_BITS = 20;

   // fixed field widths
   localparam int VOLT_W    = 16;
   localparam int ENC_W     = 32;
   localparam int ELAPSED_W = 20;

   // velocity times elapsed time, elapsed taken as a non-negative signed value
   localparam int PROD_W = ENC_W + ELAPSED_W + 1;
   // working width for position sums before saturation
   localparam int WIDE_W = ((ANGLE_WIDTH > PROD_W) ? ANGLE_WIDTH : PROD_W) + 2;

   // action codes
   localparam logic ACTION_SNAPSHOT = 1'b0;
   localparam logic ACTION_PRIME    = 1'b1;

   typedef struct packed {
      logic                     action;
      logic signed [VOLT_W-1:0] supply_voltage;
      logic signed [VOLT_W-1:0] motor_voltage;
      logic signed [VOLT_W-1:0] motor_current;
      logic signed [ENC_W-1:0]  abs_angle;
      logic signed [ENC_W-1:0]  inc_angle;
      logic signed [ENC_W-1:0]  abs_speed;
      logic signed [ENC_W-1:0]  inc_speed;
      logic [ELAPSED_W-1:0]     elapsed;
   } jefe_req_type;

   typedef struct packed {
      logic signed [ENC_W-1:0] joint_position;
      logic signed [ENC_W-1:0] joint_velocity;
      logic signed [ENC_W-1:0] inc_position_est;
      logic signed [ENC_W-1:0] abs_position_est;
      logic                    fresh;
   } jefe_rsp_type;

   typedef struct packed {
      logic [VOLT_W-1:0]             last_supply_voltage;
      logic [VOLT_W-1:0]             last_motor_voltage;
      logic [VOLT_W-1:0]             last_motor_current;
      logic [ENC_W-1:0]              last_abs_angle;
      logic [ENC_W-1:0]              last_inc_angle;
      logic [ENC_W-1:0]              last_abs_speed;
      logic [ENC_W-1:0]              last_inc_speed;
      logic signed [ANGLE_WIDTH-1:0] position_acc;
      logic signed [ENC_W-1:0]       velocity_reg;
      logic signed [ANGLE_WIDTH-1:0] inc_position_acc;
      logic signed [ANGLE_WIDTH-1:0] abs_position_acc;
   } jefe_state_type;

   // clamp a wide sum to the signed position range
   function automatic logic signed [ANGLE_WIDTH-1:0] sat_angle(
      input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-ANGLE_WIDTH:0] top_bits;
      top_bits = v[WIDE_W-1:ANGLE_WIDTH-1];
      if (&top_bits || !(|top_bits)) begin
         sat_angle = v[ANGLE_WIDTH-1:0];
      end else if (v[WIDE_W-1]) begin
         sat_angle = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      end else begin
         sat_angle = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      end
   endfunction

   // low bits of the sign-extended position
   function automatic logic signed [ENC_W-1:0] out_word(
      input logic signed [ANGLE_WIDTH-1:0] v);
      logic signed [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      out_word = w[ENC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/jefe_in_stage.sv -----
// input register stage with valid/ready handshake
`default_nettype none

module jefe_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jefe_pkg::jefe_req_type req_data,
   input  logic                  take,
   output logic                  stage_valid,
   output jefe_pkg::jefe_req_type stage_data
);
   import jefe_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   jefe_req_type data_ff;

   // refill in the same cycle the held beat moves on
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/jefe_fuse.sv -----
// change detection, source selection, extrapolation and saturation
`default_nettype none

module jefe_fuse (
   input  logic                    incremental_is_finer,
   input  jefe_pkg::jefe_req_type   req,
   input  jefe_pkg::jefe_state_type state_cur,
   output jefe_pkg::jefe_state_type state_nxt,
   output jefe_pkg::jefe_rsp_type   rsp
);
   import jefe_pkg::*;

   logic                        changed;
   logic                        fresh;
   logic signed [ELAPSED_W:0]   elapsed_s;
   logic signed [PROD_W-1:0]    prod;
   logic signed [PROD_W-1:0]    delta;
   logic signed [WIDE_W-1:0]    delta_w;
   logic signed [WIDE_W-1:0]    inc_w;
   logic signed [WIDE_W-1:0]    abs_w;
   logic signed [WIDE_W-1:0]    pos_w;
   logic signed [WIDE_W-1:0]    inc_pos_w;
   logic signed [WIDE_W-1:0]    abs_pos_w;

   assign changed = (req.supply_voltage != state_cur.last_supply_voltage)
                 || (req.motor_voltage  != state_cur.last_motor_voltage)
                 || (req.motor_current  != state_cur.last_motor_current)
                 || (req.abs_angle      != state_cur.last_abs_angle)
                 || (req.inc_angle      != state_cur.last_inc_angle)
                 || (req.abs_speed      != state_cur.last_abs_speed)
                 || (req.inc_speed      != state_cur.last_inc_speed);

   // velocity times time, arithmetic shift gives the floor
   assign elapsed_s = signed'({1'b0, req.elapsed});
   assign prod      = state_cur.velocity_reg * elapsed_s;
   assign delta     = prod >>> TIME_FRAC_BITS;

   assign delta_w   = WIDE_W'(delta);
   assign inc_w     = WIDE_W'(req.inc_angle);
   assign abs_w     = WIDE_W'(req.abs_angle);
   assign pos_w     = WIDE_W'(state_cur.position_acc);
   assign inc_pos_w = WIDE_W'(state_cur.inc_position_acc);
   assign abs_pos_w = WIDE_W'(state_cur.abs_position_acc);

   always_comb begin
      state_nxt = state_cur;
      fresh     = 1'b0;
      if (req.action == ACTION_PRIME) begin
         state_nxt.inc_position_acc = sat_angle(inc_w);
         state_nxt.abs_position_acc = sat_angle(abs_w);
         state_nxt.position_acc     = sat_angle(abs_w);
         state_nxt.velocity_reg     = '0;
      end else begin
         fresh                         = changed;
         state_nxt.last_supply_voltage = req.supply_voltage;
         state_nxt.last_motor_voltage  = req.motor_voltage;
         state_nxt.last_motor_current  = req.motor_current;
         state_nxt.last_abs_angle      = req.abs_angle;
         state_nxt.last_inc_angle      = req.inc_angle;
         state_nxt.last_abs_speed      = req.abs_speed;
         state_nxt.last_inc_speed      = req.inc_speed;
         if (changed) begin
            if (incremental_is_finer) begin
               state_nxt.velocity_reg = req.inc_speed;
               state_nxt.position_acc = sat_angle(pos_w + inc_w - inc_pos_w);
            end else begin
               state_nxt.velocity_reg = req.abs_speed;
               state_nxt.position_acc = sat_angle(abs_w);
            end
            state_nxt.inc_position_acc = sat_angle(inc_w);
            state_nxt.abs_position_acc = sat_angle(abs_w);
         end else begin
            // no new data: coast on the stored velocity
            state_nxt.position_acc     = sat_angle(pos_w + delta_w);
            state_nxt.inc_position_acc = sat_angle(inc_pos_w + delta_w);
            state_nxt.abs_position_acc = sat_angle(abs_pos_w + delta_w);
         end
      end
   end

   always_comb begin
      rsp.joint_position   = out_word(state_nxt.position_acc);
      rsp.joint_velocity   = state_nxt.velocity_reg;
      rsp.inc_position_est = out_word(state_nxt.inc_position_acc);
      rsp.abs_position_est = out_word(state_nxt.abs_position_acc);
      rsp.fresh            = fresh;
   end

endmodule

`default_nettype wire

// ----- hdl/joint_encoder_fusion_extrapolator_top.sv -----
// top level of the joint encoder fusion and extrapolation block
//
//   channel   direction   handshake                 beat
//   req_      in          req_valid / req_ready     one controller snapshot or prime
//   rsp_      out         rsp_valid / rsp_ready     fused position, velocity, estimates
//   csr_      in          csr_write_enable          incremental_is_finer, no wait
//
// one beat per cycle sustained unless rsp stalls; rsp_valid rises as a beat moves
// from the input register via update logic and multiplier into the result register
// the multiply, add and saturate for one beat fit between those two registers
// synchronous active-high reset clears valids, tracked state, csr goes to 1
// a stalled rsp holds its register and the input register; req_ready drops only
// when both are full
`default_nettype none

module joint_encoder_fusion_extrapolator_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jefe_pkg::jefe_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jefe_pkg::jefe_rsp_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);
   import jefe_pkg::*;

   `include "joint_encoder_fusion_extrapolator_top_assert.svh"

   // input register
   logic           stage_valid;
   jefe_req_type   stage_data;
   logic           advance;

   // config and tracked state
   logic           cfg_finer_ff;
   jefe_state_type state_ff;
   jefe_state_type state_in;

   // result register
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   jefe_rsp_type   rsp_data_ff;
   jefe_rsp_type   rsp_data_in;

   // a held beat moves on when the result register is empty or being drained
   assign advance = stage_valid && (!rsp_valid_ff || rsp_ready);

   jefe_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .take        (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   jefe_fuse u_fuse (
      .incremental_is_finer (cfg_finer_ff),
      .req                  (stage_data),
      .state_cur            (state_ff),
      .state_nxt            (state_in),
      .rsp                  (rsp_data_in)
   );

   // csr write, taken at once
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_finer_ff <= 1'b1;
      end else if (csr_write_enable) begin
         cfg_finer_ff <= csr_write_data;
      end
   end

   // tracked state updates once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result valid: set by a new beat, cleared when drained
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a prime beat yields a zero velocity and no fresh flag
   `JEFE_ASSERT_NEXT(prime_clears_velocity, clock, reset, advance && (stage_data.action == ACTION_PRIME), rsp_valid && !rsp_data.fresh && (rsp_data.joint_velocity == '0))

   // tracked state only moves with a beat
   `JEFE_ASSERT_NEXT(state_holds_when_idle, clock, reset, !advance, $stable(state_ff))

   // every beat that moves on shows up as a result
   `JEFE_ASSERT_NEXT(advance_gives_result, clock, reset, advance, rsp_valid)

endmodule

`default_nettype wire
